// ===== rtl/lpi_pkg.sv =====
// shared types, widths and codes for the line pair intersection block
package lpi_pkg;

    localparam int COORD_BITS = 12;
    localparam int OUT_W      = 13;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int LINE_W     = 2 * DIFF_W + 1;
    localparam int NUM_W      = DIFF_W + LINE_W + 1;
    localparam int NORM_W     = 2 * COORD_BITS + 1;
    localparam int CSQ_W      = 2 * CFG_W - 1;
    localparam int PSQ_W      = 2 * NORM_W;
    localparam int PP_W       = NORM_W + CSQ_W;
    localparam int RHS_W      = PSQ_W + CSQ_W;
    localparam int DIV_W      = NUM_W + OUT_W;
    localparam int DIV_STAGES = OUT_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE_COS = 2'd2;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_ANGLE    = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_start_x;
        logic [COORD_BITS-1:0] first_start_y;
        logic [COORD_BITS-1:0] first_end_x;
        logic [COORD_BITS-1:0] first_end_y;
        logic [COORD_BITS-1:0] second_start_x;
        logic [COORD_BITS-1:0] second_start_y;
        logic [COORD_BITS-1:0] second_end_x;
        logic [COORD_BITS-1:0] second_end_y;
    } lpi_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] cross_x;
        logic [OUT_W-1:0] cross_y;
    } lpi_out_t;

    typedef struct packed {
        logic parallel;
        logic angle_ok;
        logic x_neg;
        logic y_neg;
    } lpi_flags_t;

endpackage

// ===== rtl/lpi_geom.sv =====
// line coefficients, determinant, cramer numerators and angle test
module lpi_geom (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  lpi_pkg::lpi_in_t           in_data,
    input  logic signed [lpi_pkg::CFG_W-1:0] cos_cfg,
    output logic                       out_valid,
    output lpi_pkg::lpi_flags_t        out_flags,
    output logic [lpi_pkg::NUM_W-1:0]  num_x,
    output logic [lpi_pkg::NUM_W-1:0]  num_y,
    output logic [lpi_pkg::LINE_W-1:0] den
);
    import lpi_pkg::*;

    logic [CFG_W-1:0] cmag;
    logic [CSQ_W-1:0] csq_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1
    logic signed [DIFF_W-1:0] ux1_reg, uy1_reg, vx1_reg, vy1_reg;
    logic [COORD_BITS-1:0]    ax1_reg, ay1_reg, bx1_reg, by1_reg;

    // stage 2
    logic signed [DIFF_W-1:0] axs, ays, bxs, bys;
    logic signed [LINE_W-1:0] c1_next, c2_next, det_next, dot_next;
    logic [NORM_W-1:0]        nu_next, nv_next;
    logic signed [DIFF_W-1:0] ux2_reg, uy2_reg, vx2_reg, vy2_reg;
    logic signed [LINE_W-1:0] c1_2_reg, c2_2_reg, det2_reg, dot2_reg;
    logic [NORM_W-1:0]        nu2_reg, nv2_reg;
    logic                     fok2_reg, fbad2_reg, dneg2_reg;

    // stage 3
    logic signed [NUM_W-1:0]  nx3_reg, ny3_reg;
    logic signed [LINE_W-1:0] det3_reg;
    logic [PSQ_W-1:0]         psq3_reg;
    logic [LINE_W-1:0]        dotm_full;
    logic [NORM_W-1:0]        dotm3_reg;
    logic                     par3_reg, fok3_reg, fbad3_reg, dneg3_reg;

    // stage 4
    logic [PSQ_W-1:0]  dsq4_reg;
    logic [PP_W-1:0]   plo4_reg, phi4_reg;
    logic [NUM_W-1:0]  nxm4_reg, nym4_reg;
    logic [LINE_W-1:0] detm4_reg;
    logic              xneg4_reg, yneg4_reg, par4_reg, fok4_reg, fbad4_reg, dneg4_reg;

    // stage 5
    logic [RHS_W-1:0]  lhs5_reg, rhs5_reg;
    logic [NUM_W-1:0]  nxm5_reg, nym5_reg;
    logic [LINE_W-1:0] detm5_reg;
    logic              xneg5_reg, yneg5_reg, par5_reg, fok5_reg, fbad5_reg, dneg5_reg;

    // stage 6
    logic [NUM_W-1:0]  nxm6_reg, nym6_reg;
    logic [LINE_W-1:0] detm6_reg;
    lpi_flags_t        flags6_reg;
    logic              cmp_ok;

    assign cmag = cos_cfg[CFG_W-1] ? (~cos_cfg + 1'b1) : cos_cfg;

    always_ff @(posedge clk)
    begin
        csq_reg <= CSQ_W'(CSQ_W'(cmag) * CSQ_W'(cmag));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        axs      = $signed({1'b0, ax1_reg});
        ays      = $signed({1'b0, ay1_reg});
        bxs      = $signed({1'b0, bx1_reg});
        bys      = $signed({1'b0, by1_reg});
        c1_next  = LINE_W'(uy1_reg) * LINE_W'(axs) - LINE_W'(ux1_reg) * LINE_W'(ays);
        c2_next  = LINE_W'(vy1_reg) * LINE_W'(bxs) - LINE_W'(vx1_reg) * LINE_W'(bys);
        det_next = LINE_W'(ux1_reg) * LINE_W'(vy1_reg) - LINE_W'(uy1_reg) * LINE_W'(vx1_reg);
        dot_next = LINE_W'(ux1_reg) * LINE_W'(vx1_reg) + LINE_W'(uy1_reg) * LINE_W'(vy1_reg);
        nu_next  = NORM_W'(ux1_reg) * NORM_W'(ux1_reg) + NORM_W'(uy1_reg) * NORM_W'(uy1_reg);
        nv_next  = NORM_W'(vx1_reg) * NORM_W'(vx1_reg) + NORM_W'(vy1_reg) * NORM_W'(vy1_reg);
        dotm_full = dot2_reg[LINE_W-1] ? (~dot2_reg + 1'b1) : dot2_reg;
        cmp_ok   = dneg5_reg ? (lhs5_reg > rhs5_reg) : (lhs5_reg < rhs5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: direction vectors
            ux1_reg <= $signed({1'b0, in_data.first_end_x}) - $signed({1'b0, in_data.first_start_x});
            uy1_reg <= $signed({1'b0, in_data.first_end_y}) - $signed({1'b0, in_data.first_start_y});
            vx1_reg <= $signed({1'b0, in_data.second_end_x})
                       - $signed({1'b0, in_data.second_start_x});
            vy1_reg <= $signed({1'b0, in_data.second_end_y})
                       - $signed({1'b0, in_data.second_start_y});
            ax1_reg <= in_data.first_start_x;
            ay1_reg <= in_data.first_start_y;
            bx1_reg <= in_data.second_start_x;
            by1_reg <= in_data.second_start_y;

            // stage 2: line constants, determinant, dot and norms
            ux2_reg   <= ux1_reg;
            uy2_reg   <= uy1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            c1_2_reg  <= c1_next;
            c2_2_reg  <= c2_next;
            det2_reg  <= det_next;
            dot2_reg  <= dot_next;
            nu2_reg   <= nu_next;
            nv2_reg   <= nv_next;
            dneg2_reg <= dot_next[LINE_W-1];
            fok2_reg  <= dot_next[LINE_W-1] && !cos_cfg[CFG_W-1];
            fbad2_reg <= !dot_next[LINE_W-1] && (cos_cfg[CFG_W-1] || (cos_cfg == '0));

            // stage 3: cramer numerators, norm product
            nx3_reg   <= NUM_W'(ux2_reg) * NUM_W'(c2_2_reg) - NUM_W'(vx2_reg) * NUM_W'(c1_2_reg);
            ny3_reg   <= NUM_W'(uy2_reg) * NUM_W'(c2_2_reg) - NUM_W'(vy2_reg) * NUM_W'(c1_2_reg);
            det3_reg  <= det2_reg;
            psq3_reg  <= PSQ_W'(nu2_reg) * PSQ_W'(nv2_reg);
            dotm3_reg <= dotm_full[NORM_W-1:0];
            par3_reg  <= (det2_reg == '0);
            fok3_reg  <= fok2_reg;
            fbad3_reg <= fbad2_reg;
            dneg3_reg <= dneg2_reg;

            // stage 4: squares, split product with cosine square, magnitudes
            dsq4_reg  <= PSQ_W'(dotm3_reg) * PSQ_W'(dotm3_reg);
            plo4_reg  <= PP_W'(psq3_reg[NORM_W-1:0]) * PP_W'(csq_reg);
            phi4_reg  <= PP_W'(psq3_reg[PSQ_W-1:NORM_W]) * PP_W'(csq_reg);
            nxm4_reg  <= nx3_reg[NUM_W-1] ? (~nx3_reg + 1'b1) : nx3_reg;
            nym4_reg  <= ny3_reg[NUM_W-1] ? (~ny3_reg + 1'b1) : ny3_reg;
            detm4_reg <= det3_reg[LINE_W-1] ? (~det3_reg + 1'b1) : det3_reg;
            xneg4_reg <= nx3_reg[NUM_W-1] ^ det3_reg[LINE_W-1];
            yneg4_reg <= ny3_reg[NUM_W-1] ^ det3_reg[LINE_W-1];
            par4_reg  <= par3_reg;
            fok4_reg  <= fok3_reg;
            fbad4_reg <= fbad3_reg;
            dneg4_reg <= dneg3_reg;

            // stage 5: both sides of the angle compare
            lhs5_reg  <= RHS_W'(dsq4_reg) << (CSQ_W - 1);
            rhs5_reg  <= (RHS_W'(phi4_reg) << NORM_W) + RHS_W'(plo4_reg);
            nxm5_reg  <= nxm4_reg;
            nym5_reg  <= nym4_reg;
            detm5_reg <= detm4_reg;
            xneg5_reg <= xneg4_reg;
            yneg5_reg <= yneg4_reg;
            par5_reg  <= par4_reg;
            fok5_reg  <= fok4_reg;
            fbad5_reg <= fbad4_reg;
            dneg5_reg <= dneg4_reg;

            // stage 6: angle decision
            nxm6_reg            <= nxm5_reg;
            nym6_reg            <= nym5_reg;
            detm6_reg           <= detm5_reg;
            flags6_reg.parallel <= par5_reg;
            flags6_reg.angle_ok <= fok5_reg || (!fbad5_reg && cmp_ok);
            flags6_reg.x_neg    <= xneg5_reg;
            flags6_reg.y_neg    <= yneg5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_flags = flags6_reg;
    assign num_x     = nxm6_reg;
    assign num_y     = nym6_reg;
    assign den       = detm6_reg;

endmodule

// ===== rtl/lpi_div.sv =====
// pipelined restoring divider: an overflow check stage, then one quotient bit per stage
module lpi_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [lpi_pkg::NUM_W-1:0]  num,
    input  logic [lpi_pkg::LINE_W-1:0] den,
    output logic [lpi_pkg::OUT_W-1:0]  quot,
    output logic                       ovf
);
    import lpi_pkg::*;

    logic [DIV_W-1:0]  rem_reg  [DIV_STAGES];
    logic [LINE_W-1:0] den_reg  [DIV_STAGES];
    logic [OUT_W-1:0]  q_reg    [DIV_STAGES];
    logic              ovf_reg  [DIV_STAGES];

    logic [DIV_W-1:0]  rem_next [DIV_STAGES];
    logic [OUT_W-1:0]  q_next   [DIV_STAGES];
    logic [DIV_W-1:0]  sub      [DIV_STAGES];
    logic              ge       [DIV_STAGES];

    always_comb
    begin
        rem_next[0] = DIV_W'(num);
        q_next[0]   = '0;
        sub[0]      = DIV_W'(den) << OUT_W;
        ge[0]       = rem_next[0] >= sub[0];
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            sub[s]      = DIV_W'(den_reg[s-1]) << (OUT_W - s);
            ge[s]       = rem_reg[s-1] >= sub[s];
            rem_next[s] = ge[s] ? (rem_reg[s-1] - sub[s]) : rem_reg[s-1];
            q_next[s]   = q_reg[s-1];
            q_next[s][OUT_W-s] = ge[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            den_reg[0] <= den;
            q_reg[0]   <= q_next[0];
            ovf_reg[0] <= ge[0];
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_next[s];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];
    assign ovf  = ovf_reg[DIV_STAGES-1];

endmodule

// ===== rtl/line_pair_intersection.sv =====
// top level: config registers, geometry front end, two dividers, result stage
// path: geometry stages, divider stages, then the output register, from input beat to result beat
// throughput: one pair per cycle; the whole pipeline holds while a result beat waits
// reset: rst_n clears all valid bits and loads width 640, height 480, cosine 32767
// no clearing pass; input is taken in the first cycle after reset
module line_pair_intersection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lpi_pkg::lpi_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lpi_pkg::lpi_out_t             out_data,
    input  logic                          cfg_write,
    input  logic [lpi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpi_pkg::CFG_W-1:0]     cfg_data
);
    import lpi_pkg::*;

    logic [OUT_W-1:0]        width_reg, height_reg;
    logic signed [CFG_W-1:0] cos_reg;

    logic              en;
    logic              g_valid;
    lpi_flags_t        g_flags;
    logic [NUM_W-1:0]  g_num_x, g_num_y;
    logic [LINE_W-1:0] g_den;
    logic [OUT_W-1:0]  qx, qy;
    logic              ovfx, ovfy;

    logic              sv_reg [DIV_STAGES];
    lpi_flags_t        sf_reg [DIV_STAGES];

    logic              x_bad, y_bad;
    lpi_flags_t        fin_flags;
    logic              out_valid_reg;
    lpi_out_t          out_data_reg, out_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= OUT_W'(640);
            height_reg <= OUT_W'(480);
            cos_reg    <= 16'sd32767;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[OUT_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[OUT_W-1:0];
                REG_MIN_ANGLE_COS: cos_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    lpi_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cos_cfg   (cos_reg),
        .out_valid (g_valid),
        .out_flags (g_flags),
        .num_x     (g_num_x),
        .num_y     (g_num_y),
        .den       (g_den)
    );

    lpi_div u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (g_num_x),
        .den  (g_den),
        .quot (qx),
        .ovf  (ovfx)
    );

    lpi_div u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (g_num_y),
        .den  (g_den),
        .quot (qy),
        .ovf  (ovfy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                sv_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= g_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
            out_valid_reg <= sv_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_reg[0] <= g_flags;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                sf_reg[s] <= sf_reg[s-1];
            end
            out_data_reg <= out_next;
        end
    end

    always_comb
    begin
        fin_flags = sf_reg[DIV_STAGES-1];
        x_bad     = ovfx || (fin_flags.x_neg && (qx != '0)) || (qx > width_reg);
        y_bad     = ovfy || (fin_flags.y_neg && (qy != '0)) || (qy > height_reg);
        out_next  = '0;
        if (fin_flags.parallel)
        begin
            out_next.status = ST_PARALLEL;
        end
        else if (!fin_flags.angle_ok)
        begin
            out_next.status = ST_ANGLE;
        end
        else if (x_bad || y_bad)
        begin
            out_next.status = ST_OUTSIDE;
        end
        else
        begin
            out_next.status  = ST_ACCEPTED;
            out_next.cross_x = qx;
            out_next.cross_y = qy;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/lpi_checker.sv =====
// port level checks for the line pair intersection block and its bind
module lpi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input lpi_pkg::lpi_out_t             out_data,
    input logic                          cfg_write
);
    import lpi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_ACCEPTED) |->
        (out_data.cross_x == '0) && (out_data.cross_y == '0))
        else $error("rejected beat carries a point");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> !in_valid && !out_valid)
        else $error("register write while beats are in flight");

endmodule

bind line_pair_intersection lpi_checker u_lpi_checker (.*);
